### design/lpf4_pkg.sv
// Shared types and constants for the four-pole ladder low-pass filter.
package lpf4_pkg;

	// Coefficient register file.
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;

	// Ladder stages.
	localparam int NUM_STAGES = 4;
	localparam int STG_IDX_W  = 2;

	// Register indexes on the configuration channel.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_G       = 3'd0,
		REG_G2      = 3'd1,
		REG_G3      = 3'd2,
		REG_G4      = 3'd3,
		REG_INV_G   = 3'd4,
		REG_K       = 3'd5,
		REG_INV_KG4 = 3'd6,
		REG_MAKEUP  = 3'd7
	} reg_idx_t;

	// Sequencer states; each *_MUL state issues one product, each *_RES state consumes it.
	typedef enum logic [3:0] {
		S_IDLE,
		S_ACC0,
		S_ACC1,
		S_ACC2,
		S_ACC3,
		S_ACC4,
		S_SCL_MUL,
		S_SCL_RES,
		S_FB_MUL,
		S_FB_RES,
		S_NRM_MUL,
		S_NRM_RES,
		S_STG_MUL,
		S_STG_RES,
		S_OUT_MUL,
		S_OUT_RES
	} seq_state_t;

endpackage

### design/lpf4_mul.sv
// Shared signed-by-unsigned multiplier with optional rounding bias and a registered product.
module lpf4_mul import lpf4_pkg::*; #(
	parameter int A_W  = 34,
	parameter int B_W  = 24,
	parameter int FRAC = 21,
	localparam int PW  = A_W + B_W + 1
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic                  bias_en,
	input  logic signed [A_W-1:0] a,
	input  logic        [B_W-1:0] b,
	output logic signed [PW-1:0]  prod
);

	// Half an LSB of the rounded result, so that a floor shift rounds half up.
	localparam logic signed [PW-1:0] BIAS   = {{(PW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
	localparam logic signed [PW-1:0] ZERO_P = '0;

	logic signed [B_W:0]  b_s;
	logic signed [PW-1:0] bias_v;
	logic signed [PW-1:0] prod_q;

	assign b_s    = $signed({1'b0, b});
	assign bias_v = bias_en ? BIAS : ZERO_P;

	// Multiply-add; the product holds while the unit is not enabled.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b_s + bias_v;
		end
	end

	assign prod = prod_q;

endmodule

### design/lpf4_cfg.sv
// Coefficient register file written through the configuration channel.
module lpf4_cfg import lpf4_pkg::*; #(
	parameter int COEF_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  reg_idx_t                            wr_index,
	input  logic [COEF_BITS-1:0]                wr_data,
	output logic [NUM_REGS-1:0][COEF_BITS-1:0]  coef
);

	// Unity in unsigned Q3.(COEF_BITS-3).
	localparam logic [COEF_BITS-1:0] COEF_ONE = {2'b00, 1'b1, {(COEF_BITS-3){1'b0}}};

	logic [NUM_REGS-1:0][COEF_BITS-1:0] coef_q;

	// The scaling and makeup gains reset to unity, all others to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				coef_q[i] <= '0;
			end
			coef_q[REG_INV_G]   <= COEF_ONE;
			coef_q[REG_INV_KG4] <= COEF_ONE;
			coef_q[REG_MAKEUP]  <= COEF_ONE;
		end else if (wr_en) begin
			coef_q[wr_index] <= wr_data;
		end
	end

	assign coef = coef_q;

endmodule

### design/ladder_lowpass_4pole_zdf.sv
// Top level of the four-pole zero-delay-feedback ladder low-pass filter.
//
// Usage:
//   Samples enter on the s_axis channel, one signed sample per beat, and filtered
//   samples leave on the m_axis channel. Coefficients are written on the cfg
//   channel (cfg_index selects the register); the user must do so only while
//   the filter is idle, as the block does not enforce it. cfg_ready is always high.
//   Every sample is processed by one shared multiplier under a sequencer: the
//   weighted state sum, then a multiply step and a result step each for the
//   feedback scale, feedback and normalization, every ladder stage and the makeup
//   gain. The result is registered at the edge that ends the last step, and
//   s_axis_tready returns high at that same edge, so the block takes no new sample
//   until the current one is done. Twelve products share the single multiplier.
//   The output register holds a finished sample while the next one is
//   accepted and computed; if the receiver still stalls when the next result is
//   ready, the sequencer waits in its last step until the register frees.
//   Reset clears the stage states and the output valid, and loads the default
//   coefficients (unity scaling and makeup gain, all others zero).
module ladder_lowpass_4pole_zdf import lpf4_pkg::*; #(
	parameter int  SAMPLE_BITS = 24,
	parameter int  COEF_BITS   = 24,
	localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [COEF_BITS-1:0] cfg_data,
	// Input samples.
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [TDATA_W-1:0]   s_axis_tdata,  // sample_in, zero padded above
	// Output samples.
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [TDATA_W-1:0]   m_axis_tdata   // sample_out, zero padded above
);

	localparam int STATE_BITS = SAMPLE_BITS + 4;
	localparam int FRAC       = COEF_BITS - 3;
	localparam int A_W        = STATE_BITS + 6;
	localparam int PW         = A_W + COEF_BITS + 1;
	localparam int RW         = PW - FRAC;

	localparam logic [COEF_BITS-1:0] COEF_ONE = {2'b00, 1'b1, {FRAC{1'b0}}};

	localparam logic signed [RW-1:0] ST_MAX = {{(RW-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
	localparam logic signed [RW-1:0] ST_MIN = {{(RW-STATE_BITS+1){1'b1}}, {(STATE_BITS-1){1'b0}}};
	localparam logic signed [RW-1:0] SM_MAX = {{(RW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [RW-1:0] SM_MIN = {{(RW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

	// Saturate a rounded value to the stage-state width.
	function automatic logic signed [STATE_BITS-1:0] sat_state(input logic signed [RW-1:0] v);
		logic signed [RW-1:0] r;
		r = v;
		if (v > ST_MAX) begin
			r = ST_MAX;
		end else if (v < ST_MIN) begin
			r = ST_MIN;
		end
		return r[STATE_BITS-1:0];
	endfunction

	// Saturate a rounded value to the sample width.
	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [RW-1:0] v);
		logic signed [RW-1:0] r;
		r = v;
		if (v > SM_MAX) begin
			r = SM_MAX;
		end else if (v < SM_MIN) begin
			r = SM_MIN;
		end
		return r[SAMPLE_BITS-1:0];
	endfunction

	seq_state_t                         state_q, state_d;
	logic [STG_IDX_W-1:0]               stg_q;
	logic signed [STATE_BITS-1:0]       s_q [NUM_STAGES];
	logic signed [STATE_BITS-1:0]       w_q;
	logic signed [SAMPLE_BITS-1:0]      x_q;
	logic signed [PW-1:0]               acc_q;
	logic                               m_valid_q;
	logic [SAMPLE_BITS-1:0]             m_data_q;

	logic [NUM_REGS-1:0][COEF_BITS-1:0] coef;
	logic                               mul_en;
	logic                               mul_bias;
	logic signed [A_W-1:0]              mul_a;
	logic [COEF_BITS-1:0]               mul_b;
	logic signed [PW-1:0]               prod;

	logic                               in_beat;
	logic                               out_load;
	logic signed [STATE_BITS-1:0]       s_cur;
	logic signed [RW-1:0]               rnd_v;
	logic signed [RW-1:0]               num_full;
	logic signed [RW-1:0]               o_full;
	logic signed [STATE_BITS-1:0]       o_sat;
	logic signed [RW-1:0]               ov_full;
	logic signed [STATE_BITS-1:0]       s_new;

	lpf4_cfg #(
		.COEF_BITS (COEF_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (reg_idx_t'(cfg_index)),
		.wr_data  (cfg_data),
		.coef     (coef)
	);

	lpf4_mul #(
		.A_W  (A_W),
		.B_W  (COEF_BITS),
		.FRAC (FRAC)
	) u_mul (
		.clk     (clk),
		.en      (mul_en),
		.bias_en (mul_bias),
		.a       (mul_a),
		.b       (mul_b),
		.prod    (prod)
	);

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == S_OUT_RES) && (!m_valid_q || m_axis_tready);

	// The product already carries the rounding bias, so the floor shift rounds.
	assign rnd_v    = prod[PW-1:FRAC];
	assign s_cur    = s_q[stg_q];
	assign num_full = {{(RW-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q} - rnd_v;

	// One trapezoidal stage: out = v + s, new state = out + v.
	assign o_full  = rnd_v + {{(RW-STATE_BITS){s_cur[STATE_BITS-1]}}, s_cur};
	assign o_sat   = sat_state(o_full);
	assign ov_full = rnd_v + {{(RW-STATE_BITS){o_sat[STATE_BITS-1]}}, o_sat};
	assign s_new   = sat_state(ov_full);

	// State register of the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and multiplier operands.
	always_comb begin
		state_d  = state_q;
		mul_en   = 1'b0;
		mul_bias = 1'b1;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = S_ACC0;
				end
			end
			S_ACC0: begin
				mul_en  = 1'b1;
				mul_a   = {{(A_W-STATE_BITS){s_q[0][STATE_BITS-1]}}, s_q[0]};
				mul_b   = coef[REG_G3];
				state_d = S_ACC1;
			end
			S_ACC1: begin
				mul_en   = 1'b1;
				mul_bias = 1'b0;
				mul_a    = {{(A_W-STATE_BITS){s_q[1][STATE_BITS-1]}}, s_q[1]};
				mul_b    = coef[REG_G2];
				state_d  = S_ACC2;
			end
			S_ACC2: begin
				mul_en   = 1'b1;
				mul_bias = 1'b0;
				mul_a    = {{(A_W-STATE_BITS){s_q[2][STATE_BITS-1]}}, s_q[2]};
				mul_b    = coef[REG_G];
				state_d  = S_ACC3;
			end
			S_ACC3: begin
				mul_en   = 1'b1;
				mul_bias = 1'b0;
				mul_a    = {{(A_W-STATE_BITS){s_q[3][STATE_BITS-1]}}, s_q[3]};
				mul_b    = COEF_ONE;
				state_d  = S_ACC4;
			end
			S_ACC4: begin
				state_d = S_SCL_MUL;
			end
			S_SCL_MUL: begin
				mul_en  = 1'b1;
				mul_a   = acc_q[FRAC+A_W-1:FRAC];
				mul_b   = coef[REG_INV_G];
				state_d = S_SCL_RES;
			end
			S_SCL_RES: begin
				state_d = S_FB_MUL;
			end
			S_FB_MUL: begin
				mul_en  = 1'b1;
				mul_a   = {{(A_W-STATE_BITS){w_q[STATE_BITS-1]}}, w_q};
				mul_b   = coef[REG_K];
				state_d = S_FB_RES;
			end
			S_FB_RES: begin
				state_d = S_NRM_MUL;
			end
			S_NRM_MUL: begin
				mul_en  = 1'b1;
				mul_a   = {{(A_W-STATE_BITS){w_q[STATE_BITS-1]}}, w_q};
				mul_b   = coef[REG_INV_KG4];
				state_d = S_NRM_RES;
			end
			S_NRM_RES: begin
				state_d = S_STG_MUL;
			end
			S_STG_MUL: begin
				mul_en  = 1'b1;
				mul_a   = {{(A_W-STATE_BITS){w_q[STATE_BITS-1]}}, w_q}
				        - {{(A_W-STATE_BITS){s_cur[STATE_BITS-1]}}, s_cur};
				mul_b   = coef[REG_G];
				state_d = S_STG_RES;
			end
			S_STG_RES: begin
				if (stg_q == STG_IDX_W'(NUM_STAGES - 1)) begin
					state_d = S_OUT_MUL;
				end else begin
					state_d = S_STG_MUL;
				end
			end
			S_OUT_MUL: begin
				mul_en  = 1'b1;
				mul_a   = {{(A_W-STATE_BITS){w_q[STATE_BITS-1]}}, w_q};
				mul_b   = coef[REG_MAKEUP];
				state_d = S_OUT_RES;
			end
			S_OUT_RES: begin
				if (!m_valid_q || m_axis_tready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Stage index and stage states.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_q <= '0;
			for (int i = 0; i < NUM_STAGES; i++) begin
				s_q[i] <= '0;
			end
		end else if (state_q == S_STG_RES) begin
			s_q[stg_q] <= s_new;
			if (stg_q == STG_IDX_W'(NUM_STAGES - 1)) begin
				stg_q <= '0;
			end else begin
				stg_q <= stg_q + STG_IDX_W'(1);
			end
		end
	end

	// Working registers: input sample, state-sum accumulator and running value.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			x_q <= s_axis_tdata[SAMPLE_BITS-1:0];
		end
		case (state_q)
			S_ACC1:                 acc_q <= prod;
			S_ACC2, S_ACC3, S_ACC4: acc_q <= acc_q + prod;
			S_SCL_RES:              w_q   <= sat_state(rnd_v);
			S_FB_RES:               w_q   <= sat_state(num_full);
			S_NRM_RES:              w_q   <= sat_state(rnd_v);
			S_STG_RES:              w_q   <= o_sat;
			default: begin
			end
		endcase
		if (out_load) begin
			m_data_q <= sat_sample(rnd_v);
		end
	end

	// Output register valid: set on a new result, cleared when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = TDATA_W'(m_data_q);

`ifndef SYNTHESIS
	// An accepted sample always starts the state-sum sequence.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> state_q == S_ACC0)
		else $error("accepted sample did not start the sequence");

	// The stage index is back at zero outside the ladder steps.
	a_stg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_STG_MUL && state_q != S_STG_RES) |-> stg_q == '0)
		else $error("stage index not cleared outside the ladder");

	// A result is only produced from the last step of the sequence.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == S_OUT_RES)
		else $error("output valid rose outside the final step");

	// Leaving the final step always leaves a result in the output register.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT_RES && state_d == S_IDLE) |=> m_axis_tvalid)
		else $error("final step finished without a result");
`endif

endmodule

### verif/ladder_lowpass_4pole_zdf_tb.sv
// Self-checking testbench for the four-pole zero-delay-feedback ladder low-pass filter.
`timescale 1ns / 100ps

module ladder_lowpass_4pole_zdf_tb;
	import lpf4_pkg::*;

	localparam int     SMP_W          = 24;
	localparam int     STATE_W        = 28;
	localparam int     FRAC           = 21;
	localparam longint UNITY          = 64'sd1 << FRAC;
	localparam longint HALF_LSB       = 64'sd1 << (FRAC - 1);
	localparam longint COEF_MAX       = (64'sd1 << 24) - 1;
	localparam int     MAX_WAIT       = 17;
	localparam int     SETTLE_CYCLES  = 25;
	localparam int     LONG_HOLD      = 300;
	localparam int     NUM_PHASES     = 10;
	localparam int     RAND_PER_PHASE = 98;
	localparam int     DRAIN_LIMIT    = 20000;
	localparam int     RUN_LIMIT_NS   = 5_000_000;

	// Directed stimulus: register writes and samples in order. A sample row with chk set
	// carries its expected output; the rest are checked against the predictor.
	typedef enum logic {ROW_SMP, ROW_CFG} row_kind_t;
	typedef struct packed {
		row_kind_t        kind;
		reg_idx_t         idx;
		logic [SMP_W-1:0] val;
		logic             chk;
		logic [SMP_W-1:0] want;
	} dir_row_t;

	localparam int DIR_ROWS = 40;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// Reset coefficients: zero stage gain freezes the ladder, output stays zero.
		'{ROW_SMP, REG_G,       24'h7FFFFF, 1'b1, 24'h000000},
		'{ROW_SMP, REG_G,       24'h800000, 1'b1, 24'h000000},
		'{ROW_SMP, REG_G,       24'h000001, 1'b1, 24'h000000},
		// Unity stage gain, no resonance: every stage passes its input through.
		'{ROW_CFG, REG_G,       24'h200000, 1'b0, 24'h000000},
		'{ROW_CFG, REG_G2,      24'h200000, 1'b0, 24'h000000},
		'{ROW_CFG, REG_G3,      24'h200000, 1'b0, 24'h000000},
		'{ROW_CFG, REG_G4,      24'h200000, 1'b0, 24'h000000},
		'{ROW_CFG, REG_INV_G,   24'h200000, 1'b0, 24'h000000},
		'{ROW_CFG, REG_K,       24'h000000, 1'b0, 24'h000000},
		'{ROW_CFG, REG_INV_KG4, 24'h200000, 1'b0, 24'h000000},
		'{ROW_CFG, REG_MAKEUP,  24'h200000, 1'b0, 24'h000000},
		'{ROW_SMP, REG_G,       24'h7FFFFF, 1'b1, 24'h7FFFFF},
		'{ROW_SMP, REG_G,       24'h800000, 1'b1, 24'h800000},
		'{ROW_SMP, REG_G,       24'h000000, 1'b1, 24'h000000},
		'{ROW_SMP, REG_G,       24'h000001, 1'b1, 24'h000001},
		'{ROW_SMP, REG_G,       24'hFFFFFF, 1'b1, 24'hFFFFFF},
		'{ROW_SMP, REG_G,       24'h555555, 1'b1, 24'h555555},
		'{ROW_SMP, REG_G,       24'hAAAAAA, 1'b1, 24'hAAAAAA},
		// Largest makeup gain: full-scale inputs saturate the output.
		'{ROW_CFG, REG_MAKEUP,  24'hFFFFFF, 1'b0, 24'h000000},
		'{ROW_SMP, REG_G,       24'h7FFFFF, 1'b1, 24'h7FFFFF},
		'{ROW_SMP, REG_G,       24'h800000, 1'b1, 24'h800000},
		'{ROW_SMP, REG_G,       24'h000001, 1'b0, 24'h000000},
		'{ROW_SMP, REG_G,       24'h000000, 1'b1, 24'h000000},
		// Zero makeup gain mutes the output.
		'{ROW_CFG, REG_MAKEUP,  24'h000000, 1'b0, 24'h000000},
		'{ROW_SMP, REG_G,       24'h7FFFFF, 1'b1, 24'h000000},
		'{ROW_SMP, REG_G,       24'h800000, 1'b1, 24'h000000},
		// Every coefficient at its maximum, strongest resonance.
		'{ROW_CFG, REG_G,       24'hFFFFFF, 1'b0, 24'h000000},
		'{ROW_CFG, REG_G2,      24'hFFFFFF, 1'b0, 24'h000000},
		'{ROW_CFG, REG_G3,      24'hFFFFFF, 1'b0, 24'h000000},
		'{ROW_CFG, REG_G4,      24'hFFFFFF, 1'b0, 24'h000000},
		'{ROW_CFG, REG_INV_G,   24'hFFFFFF, 1'b0, 24'h000000},
		'{ROW_CFG, REG_K,       24'hFFFFFF, 1'b0, 24'h000000},
		'{ROW_CFG, REG_INV_KG4, 24'hFFFFFF, 1'b0, 24'h000000},
		'{ROW_CFG, REG_MAKEUP,  24'hFFFFFF, 1'b0, 24'h000000},
		'{ROW_SMP, REG_G,       24'h7FFFFF, 1'b0, 24'h000000},
		'{ROW_SMP, REG_G,       24'h800000, 1'b0, 24'h000000},
		'{ROW_SMP, REG_G,       24'h000000, 1'b0, 24'h000000},
		'{ROW_SMP, REG_G,       24'h7FFFFF, 1'b0, 24'h000000},
		'{ROW_SMP, REG_G,       24'h800000, 1'b0, 24'h000000},
		'{ROW_SMP, REG_G,       24'h123456, 1'b0, 24'h000000}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [23:0]          cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [23:0]          s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [23:0]          m_axis_tdata;

	// Predictor copy of the coefficients and the ladder stage states.
	longint coef_reg [NUM_REGS];
	longint coef_plan [NUM_REGS];
	longint stage_acc [NUM_STAGES];

	logic [SMP_W-1:0] pending_out [$];
	int               err_count;
	int               samples_sent;
	int               results_seen;
	int               cfg_writes;
	int               coef_sets;
	int               long_hold;
	bit               tx_idle;
	bit               rx_idle;

	always #5 clk = ~clk;

	ladder_lowpass_4pole_zdf dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	function automatic longint clamp(longint v, int bits);
		longint hi;
		longint lo;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// Round half up to Q.23 after a product with a Q3.21 coefficient.
	function automatic longint round_q21(longint v);
		return (v + HALF_LSB) >>> FRAC;
	endfunction

	// Filters one sample through the ladder, updating the stage states.
	function automatic logic [SMP_W-1:0] ladder_step(logic [SMP_W-1:0] smp);
		longint x, acc, ssum, sbar, num, y, v, o;
		int     n;
		x = longint'($signed(smp));
		acc = stage_acc[0] * coef_reg[REG_G3] + stage_acc[1] * coef_reg[REG_G2]
			+ stage_acc[2] * coef_reg[REG_G] + stage_acc[3] * UNITY;
		ssum = round_q21(acc);
		sbar = clamp(round_q21(ssum * coef_reg[REG_INV_G]), STATE_W);
		num = clamp(x - round_q21(coef_reg[REG_K] * sbar), STATE_W);
		y = clamp(round_q21(num * coef_reg[REG_INV_KG4]), STATE_W);
		for (n = 0; n < NUM_STAGES; n++) begin
			v = round_q21((y - stage_acc[n]) * coef_reg[REG_G]);
			o = clamp(v + stage_acc[n], STATE_W);
			stage_acc[n] = clamp(o + v, STATE_W);
			y = o;
		end
		y = clamp(round_q21(y * coef_reg[REG_MAKEUP]), SMP_W);
		return y[SMP_W-1:0];
	endfunction

	// Mix of full-scale values, held values (step response), full-range noise and small signals.
	function automatic logic [SMP_W-1:0] draw_sample(logic [SMP_W-1:0] prev);
		int unsigned pick;
		logic [31:0] r;
		pick = $urandom_range(0, 19);
		r = $urandom();
		case (pick)
			0:             return 24'h7FFFFF;
			1:             return 24'h800000;
			2:             return 24'h000000;
			3, 4, 5:       return prev;
			6, 7, 8, 9, 10, 11, 12: return r[SMP_W-1:0];
			default:       return 24'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
		endcase
	endfunction

	// Sends one sample beat, after a random gap while tx_idle is set; the prediction is queued at acceptance.
	task automatic push_sample(input logic [SMP_W-1:0] smp, input logic chk,
			input logic [SMP_W-1:0] want);
		int               gap;
		logic [SMP_W-1:0] got;
		gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		got = ladder_step(smp);
		pending_out.push_back(chk ? want : got);
		samples_sent++;
		@(negedge clk);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write of a batch.
	task automatic write_reg(input reg_idx_t idx, input longint val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[23:0];
		do @(posedge clk); while (cfg_ready !== 1'b1);
		coef_reg[idx] = val & COEF_MAX;
		cfg_writes++;
		@(negedge clk);
	endtask

	// Stops offering samples and waits until the filter has delivered everything.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_out.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_plan();
		int r;
		for (r = 0; r < NUM_REGS; r++) write_reg(reg_idx_t'(r), coef_plan[r]);
		cfg_valid <= 1'b0;
		coef_sets++;
	endtask

	// Coefficients as software derives them from a stage gain G and a resonance k.
	task automatic plan_tuned(input longint gq, input longint kq);
		longint g2, g3, g4, den;
		g2 = round_q21(gq * gq);
		g3 = round_q21(g2 * gq);
		g4 = round_q21(g3 * gq);
		den = UNITY + round_q21(kq * g4);
		coef_plan[REG_G]       = gq;
		coef_plan[REG_G2]      = g2;
		coef_plan[REG_G3]      = g3;
		coef_plan[REG_G4]      = g4;
		coef_plan[REG_INV_G]   = UNITY - gq;
		coef_plan[REG_K]       = kq;
		coef_plan[REG_INV_KG4] = (UNITY * UNITY + den / 2) / den;
		coef_plan[REG_MAKEUP]  = (UNITY + kq > COEF_MAX) ? COEF_MAX : UNITY + kq;
	endtask

	// Result side: random stalls per beat while rx_idle is set, one long hold on request, and the checker.
	initial begin : out_sink
		int               stall;
		logic [SMP_W-1:0] want;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold > 0) begin
				stall = long_hold;
				long_hold = 0;
			end else begin
				stall = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid === 1'b1 && m_axis_tready));
			results_seen++;
			if (pending_out.size() == 0) begin
				$error("sample_out: unexpected beat, got %0d", $signed(m_axis_tdata));
				err_count++;
			end else begin
				want = pending_out.pop_front();
				if (m_axis_tdata !== want) begin
					$error("sample_out: expected %0d, got %0d", $signed(want),
						$signed(m_axis_tdata));
					err_count++;
				end
			end
		end
	end

	// Hard limit on the whole run.
	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("ladder_lowpass_4pole_zdf_tb: errors");
		$finish;
	end

	initial begin : stimulus
		logic [SMP_W-1:0] smp;
		bit               cfg_open;
		int               waited;
		int               r;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_G;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		err_count     = 0;
		samples_sent  = 0;
		results_seen  = 0;
		cfg_writes    = 0;
		coef_sets     = 1;
		long_hold     = 0;
		tx_idle       = 1'b1;
		rx_idle       = 1'b1;
		cfg_open      = 1'b0;
		smp           = '0;
		for (r = 0; r < NUM_REGS; r++) coef_reg[r] = 0;
		coef_reg[REG_INV_G]   = UNITY;
		coef_reg[REG_INV_KG4] = UNITY;
		coef_reg[REG_MAKEUP]  = UNITY;
		for (r = 0; r < NUM_STAGES; r++) stage_acc[r] = 0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows; a run of register writes starts only once the filter is idle.
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIR_TABLE[i].kind == ROW_CFG) begin
				if (!cfg_open) begin
					drain_results();
					cfg_open = 1'b1;
					coef_sets++;
				end
				write_reg(DIR_TABLE[i].idx, longint'(DIR_TABLE[i].val));
			end else begin
				if (cfg_open) begin
					cfg_valid <= 1'b0;
					cfg_open = 1'b0;
				end
				push_sample(DIR_TABLE[i].val, DIR_TABLE[i].chk, DIR_TABLE[i].want);
			end
		end

		// Random phases, each under its own coefficient set and idling pattern.
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			tx_idle = (p % 3) != 0;
			rx_idle = (p % 4) != 1;
			case (p)
				3, 9: begin
					for (r = 0; r < NUM_REGS; r++) coef_plan[r] = $urandom_range(0, COEF_MAX);
				end
				5: plan_tuned($urandom_range(UNITY / 4, UNITY),
					$urandom_range(7 * UNITY / 2, 4 * UNITY));
				7: begin
					for (r = 0; r < NUM_REGS; r++) coef_plan[r] = 0;
				end
				default: plan_tuned($urandom_range(0, UNITY), $urandom_range(0, 4 * UNITY));
			endcase
			load_plan();
			// Back-pressure: the receiver stops for a long stretch while samples keep coming.
			if (p == 2) begin
				tx_idle = 1'b0;
				long_hold = LONG_HOLD;
			end
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				if (p == 6 && n == RAND_PER_PHASE / 2) drain_results();
				smp = draw_sample(smp);
				push_sample(smp, 1'b0, '0);
			end
		end

		// Wait out the remaining results, bounded.
		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (pending_out.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (pending_out.size() != 0) begin
			$error("sample_out: %0d results never arrived", pending_out.size());
			err_count += pending_out.size();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("summary: %0d samples under %0d coefficient sets, %0d register writes",
			samples_sent, coef_sets, cfg_writes);
		$display("summary: %0d output beats checked, %0d mismatches", results_seen, err_count);
		if (err_count == 0) begin
			$display("ladder_lowpass_4pole_zdf_tb: clean");
		end else begin
			$display("ladder_lowpass_4pole_zdf_tb: errors");
		end
		$finish;
	end

endmodule

### files.f
design/lpf4_pkg.sv
design/lpf4_mul.sv
design/lpf4_cfg.sv
design/ladder_lowpass_4pole_zdf.sv
verif/ladder_lowpass_4pole_zdf_tb.sv
